@@ src/twpm_pkg.sv @@
// shared types, constants and helpers for the three-way position merge
package twpm_pkg;

    localparam int LIST_DEPTH     = 4096;
    localparam int POSITION_BITS  = 31;
    localparam int NUM_LISTS      = 3;
    localparam int INDEX_BITS     = $clog2(LIST_DEPTH);
    localparam int CNT_BITS       = $clog2(LIST_DEPTH + 1);
    localparam int OUT_INDEX_BITS = 12;
    localparam int STORE_DEPTH    = NUM_LISTS * LIST_DEPTH;
    localparam int ADDR_BITS      = $clog2(STORE_DEPTH);
    localparam int SEL_BITS       = 2;

    localparam logic                OP_LOAD   = 1'b0;
    localparam logic                OP_NEXT   = 1'b1;
    localparam logic [SEL_BITS-1:0] LIST_LAST = SEL_BITS'(NUM_LISTS - 1);

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [CNT_BITS-1:0]      cnt_t;
    typedef logic [INDEX_BITS-1:0]    idx_t;
    typedef logic [ADDR_BITS-1:0]     addr_t;
    typedef logic [SEL_BITS-1:0]      sel_t;
    typedef logic [OUT_INDEX_BITS-1:0] out_idx_t;

    typedef struct packed {
        logic  opcode;
        sel_t  sample;
        pos_t  original_position;
        pos_t  start_position;
    } twpm_item_t;

    typedef struct packed {
        logic     success;
        logic     mother_valid;
        out_idx_t mother_index;
        logic     father_valid;
        out_idx_t father_index;
        logic     child_valid;
        out_idx_t child_index;
    } twpm_result_t;

    typedef struct packed {
        pos_t original_position;
        pos_t start_position;
    } twpm_entry_t;

    typedef struct packed {
        logic        we;
        addr_t       waddr;
        twpm_entry_t wdata;
        logic        re;
        addr_t       raddr;
    } twpm_mem_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CMP,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_DECIDE,
        ST_START_RD,
        ST_START_CMP,
        ST_EMIT
    } twpm_state_t;

    // flat store address of entry idx in list sel
    function automatic addr_t entry_addr(input sel_t sel, input idx_t idx);
        addr_t base;
        base = addr_t'(sel) * addr_t'(LIST_DEPTH);
        return base + addr_t'(idx);
    endfunction

endpackage

@@ src/twpm_store.sv @@
// entry store: one write port, one read port, registered read data
module twpm_store (
    input  logic                   clk,
    input  twpm_pkg::twpm_mem_req_t req,
    output twpm_pkg::twpm_entry_t   rdata
);
    import twpm_pkg::*;

    twpm_entry_t mem [0:STORE_DEPTH-1];
    twpm_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/twpm_ctrl.sv @@
// list pointers, window control and merge sequencer
module twpm_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  twpm_pkg::twpm_item_t    item,
    output logic                    busy,
    output twpm_pkg::twpm_mem_req_t mem_req,
    input  twpm_pkg::twpm_entry_t   rdata,
    output logic                    emit,
    output twpm_pkg::twpm_result_t  emit_result
);
    import twpm_pkg::*;

    twpm_state_t state_reg, state_next;
    sel_t        lst_reg, lst_next;
    cnt_t        cnt_reg [0:NUM_LISTS-1];
    cnt_t        cnt_next [0:NUM_LISTS-1];
    cnt_t        rp_reg [0:NUM_LISTS-1];
    cnt_t        rp_next [0:NUM_LISTS-1];
    cnt_t        wh_reg [0:NUM_LISTS-1];
    cnt_t        wh_next [0:NUM_LISTS-1];
    pos_t        start_reg [0:NUM_LISTS-1];
    pos_t        start_next [0:NUM_LISTS-1];
    logic [NUM_LISTS-1:0] cand_reg, cand_next;
    pos_t        group_pos_reg, group_pos_next;
    pos_t        min_start_reg, min_start_next;
    logic        found_reg, found_next;
    logic        any_reg, any_next;
    logic        success_reg, success_next;

    logic        accept;
    logic        load_ok;
    cnt_t        load_cnt;
    cnt_t        cur_rp, cur_cnt, cur_wh;
    logic        has_more, win_nonempty, last;
    logic        all_empty, multi;
    logic        find_better;
    logic [NUM_LISTS-1:0] give, win_valid;

    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        load_ok  = 1'b0;
        load_cnt = '0;
        for (int s = 0; s < NUM_LISTS; s++)
        begin
            if (item.sample == sel_t'(s))
            begin
                load_ok  = (cnt_reg[s] < cnt_t'(LIST_DEPTH));
                load_cnt = cnt_reg[s];
            end
        end
    end

    assign cur_rp       = rp_reg[lst_reg];
    assign cur_cnt      = cnt_reg[lst_reg];
    assign cur_wh       = wh_reg[lst_reg];
    assign has_more     = cur_rp < cur_cnt;
    assign win_nonempty = cur_wh < cur_rp;
    assign last         = (lst_reg == LIST_LAST);
    assign find_better  = !found_reg || (rdata.original_position < group_pos_reg);

    always_comb
    begin
        all_empty = 1'b1;
        multi     = 1'b0;
        for (int s = 0; s < NUM_LISTS; s++)
        begin
            win_valid[s] = wh_reg[s] < rp_reg[s];
            give[s]      = cand_reg[s] && (start_reg[s] == min_start_reg);
            if (wh_reg[s] != rp_reg[s])
            begin
                all_empty = 1'b0;
            end
            if (cnt_t'(rp_reg[s] - wh_reg[s]) > cnt_t'(1))
            begin
                multi = 1'b1;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.opcode == OP_NEXT)
                begin
                    state_next = all_empty ? ST_FIND_RD : ST_DECIDE;
                end
            end
            ST_FIND_RD:
            begin
                if (has_more)
                begin
                    state_next = ST_FIND_CMP;
                end
                else if (last)
                begin
                    state_next = found_reg ? ST_WALK_RD : ST_DECIDE;
                end
            end
            ST_FIND_CMP:
            begin
                state_next = last ? ST_WALK_RD : ST_FIND_RD;
            end
            ST_WALK_RD:
            begin
                if (has_more)
                begin
                    state_next = ST_WALK_CMP;
                end
                else if (last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_WALK_CMP:
            begin
                if (rdata.original_position == group_pos_reg)
                begin
                    state_next = ST_WALK_RD;
                end
                else
                begin
                    state_next = last ? ST_DECIDE : ST_WALK_RD;
                end
            end
            ST_DECIDE:
            begin
                state_next = multi ? ST_START_RD : ST_IDLE;
            end
            ST_START_RD:
            begin
                if (win_nonempty)
                begin
                    state_next = ST_START_CMP;
                end
                else if (last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_START_CMP:
            begin
                state_next = last ? ST_EMIT : ST_START_RD;
            end
            ST_EMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        lst_next       = lst_reg;
        cnt_next       = cnt_reg;
        rp_next        = rp_reg;
        wh_next        = wh_reg;
        start_next     = start_reg;
        cand_next      = cand_reg;
        group_pos_next = group_pos_reg;
        min_start_next = min_start_reg;
        found_next     = found_reg;
        any_next       = any_reg;
        success_next   = success_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.opcode == OP_LOAD && load_ok)
                begin
                    for (int s = 0; s < NUM_LISTS; s++)
                    begin
                        if (item.sample == sel_t'(s))
                        begin
                            cnt_next[s] = cnt_reg[s] + cnt_t'(1);
                        end
                    end
                end
                if (accept && item.opcode == OP_NEXT)
                begin
                    lst_next     = '0;
                    found_next   = 1'b0;
                    success_next = 1'b1;
                end
            end
            ST_FIND_RD:
            begin
                if (!has_more)
                begin
                    if (last)
                    begin
                        lst_next     = '0;
                        success_next = found_reg;
                    end
                    else
                    begin
                        lst_next = lst_reg + sel_t'(1);
                    end
                end
            end
            ST_FIND_CMP:
            begin
                if (find_better)
                begin
                    group_pos_next = rdata.original_position;
                    found_next     = 1'b1;
                end
                lst_next = last ? sel_t'(0) : lst_reg + sel_t'(1);
            end
            ST_WALK_RD:
            begin
                if (!has_more && !last)
                begin
                    lst_next = lst_reg + sel_t'(1);
                end
            end
            ST_WALK_CMP:
            begin
                if (rdata.original_position == group_pos_reg)
                begin
                    rp_next[lst_reg] = cur_rp + cnt_t'(1);
                end
                else if (!last)
                begin
                    lst_next = lst_reg + sel_t'(1);
                end
            end
            ST_DECIDE:
            begin
                lst_next = '0;
                any_next = 1'b0;
                if (!multi)
                begin
                    wh_next = rp_reg;
                end
            end
            ST_START_RD:
            begin
                if (!win_nonempty)
                begin
                    cand_next[lst_reg] = 1'b0;
                    if (!last)
                    begin
                        lst_next = lst_reg + sel_t'(1);
                    end
                end
            end
            ST_START_CMP:
            begin
                start_next[lst_reg] = rdata.start_position;
                cand_next[lst_reg]  = 1'b1;
                if (!any_reg || rdata.start_position < min_start_reg)
                begin
                    min_start_next = rdata.start_position;
                    any_next       = 1'b1;
                end
                if (!last)
                begin
                    lst_next = lst_reg + sel_t'(1);
                end
            end
            ST_EMIT:
            begin
                for (int s = 0; s < NUM_LISTS; s++)
                begin
                    if (give[s])
                    begin
                        wh_next[s] = wh_reg[s] + cnt_t'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        logic     vld [0:NUM_LISTS-1];
        out_idx_t idx [0:NUM_LISTS-1];

        busy          = (state_reg != ST_IDLE);
        mem_req.we    = accept && (item.opcode == OP_LOAD) && load_ok;
        mem_req.waddr = entry_addr(item.sample, idx_t'(load_cnt));
        mem_req.wdata.original_position = item.original_position;
        mem_req.wdata.start_position    = item.start_position;
        mem_req.re    = 1'b0;
        mem_req.raddr = entry_addr(lst_reg, idx_t'(cur_rp));
        emit          = 1'b0;
        for (int s = 0; s < NUM_LISTS; s++)
        begin
            vld[s] = 1'b0;
            idx[s] = '0;
        end
        unique case (state_reg) inside
            ST_FIND_RD, ST_WALK_RD:
            begin
                mem_req.re = has_more;
            end
            ST_START_RD:
            begin
                mem_req.re    = win_nonempty;
                mem_req.raddr = entry_addr(lst_reg, idx_t'(cur_wh));
            end
            ST_DECIDE:
            begin
                emit = !multi;
                for (int s = 0; s < NUM_LISTS; s++)
                begin
                    vld[s] = win_valid[s];
                end
            end
            ST_EMIT:
            begin
                emit = 1'b1;
                for (int s = 0; s < NUM_LISTS; s++)
                begin
                    vld[s] = give[s];
                end
            end
            default:
            begin
            end
        endcase
        for (int s = 0; s < NUM_LISTS; s++)
        begin
            idx[s] = vld[s] ? out_idx_t'(wh_reg[s]) : '0;
        end
        emit_result.success      = success_reg;
        emit_result.mother_valid = vld[0];
        emit_result.mother_index = idx[0];
        emit_result.father_valid = vld[1];
        emit_result.father_index = idx[1];
        emit_result.child_valid  = vld[2];
        emit_result.child_index  = idx[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lst_reg       <= '0;
            cand_reg      <= '0;
            group_pos_reg <= '0;
            min_start_reg <= '0;
            found_reg     <= 1'b0;
            any_reg       <= 1'b0;
            success_reg   <= 1'b1;
            for (int s = 0; s < NUM_LISTS; s++)
            begin
                cnt_reg[s] <= '0;
                rp_reg[s]  <= '0;
                wh_reg[s]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            lst_reg       <= lst_next;
            cand_reg      <= cand_next;
            group_pos_reg <= group_pos_next;
            min_start_reg <= min_start_next;
            found_reg     <= found_next;
            any_reg       <= any_next;
            success_reg   <= success_next;
            cnt_reg       <= cnt_next;
            rp_reg        <= rp_next;
            wh_reg        <= wh_next;
        end
    end

    // start positions are payload only
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
    end

endmodule

@@ src/three_way_position_merge.sv @@
// top level of the three-way position merge with its result register
//
//  port           dir  beat marked by          payload
//  start/item     in   start && !busy          twpm_item_t (opcode, sample, positions)
//  done/result    out  done, one cycle only    twpm_result_t (success, valid/index per list)
//
// a load beat is taken without raising busy; a next beat holds busy for a refill when every
// window is empty (per list a front read and compare, then a walk over the entries of
// the lowest group), a decide state, and on a split a front read per open window, an emit
// reset clears all list counts and pointers, the store needs no clearing
// results cannot be held off: done is registered from the emit and rises in the cycle after it, once per next beat
module three_way_position_merge (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  twpm_pkg::twpm_item_t   item,
    output logic                   busy,
    output logic                   done,
    output twpm_pkg::twpm_result_t result
);
    import twpm_pkg::*;

    twpm_mem_req_t mem_req;
    twpm_entry_t   rdata;
    logic          emit;
    twpm_result_t  emit_result;
    logic          done_reg;
    twpm_result_t  result_reg;

    twpm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .item        (item),
        .busy        (busy),
        .mem_req     (mem_req),
        .rdata       (rdata),
        .emit        (emit),
        .emit_result (emit_result)
    );

    twpm_store u_store (
        .clk   (clk),
        .req   (mem_req),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= emit_result;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

@@ tb/tb.sv @@
// self-checking testbench for the three-way position merge
`timescale 1ns / 100ps

module tb;
    import twpm_pkg::*;

    localparam sel_t MOTHER  = 2'd0;
    localparam sel_t FATHER  = 2'd1;
    localparam sel_t CHILD   = 2'd2;
    localparam sel_t NO_LIST = 2'd3;

    localparam pos_t POS_HIGH     = 31'd2147483646;
    localparam int   RANDOM_ITEMS = 1500;
    localparam int   CYCLE_LIMIT  = 4000000;
    localparam int   DRAIN_LIMIT  = 200000;
    localparam int   TAIL_CYCLES  = 40;

    typedef struct {
        twpm_item_t   it;
        bit           has_exp;
        twpm_result_t ex;
    } plan_row_t;

    logic         clk   = 1'b0;
    logic         rst_n = 1'b0;
    logic         start = 1'b0;
    twpm_item_t   item  = '0;
    logic         busy;
    logic         done;
    twpm_result_t result;

    // expectation typed into the directed table, travels with the beat
    bit           beat_has_exp = 1'b0;
    twpm_result_t beat_exp     = '0;
    bit           no_gaps      = 1'b0;

    // shadow of the merge state
    pos_t list_orig  [NUM_LISTS][LIST_DEPTH];
    pos_t list_start [NUM_LISTS][LIST_DEPTH];
    int   list_len   [NUM_LISTS];
    int   gather_ptr [NUM_LISTS];
    int   emit_ptr   [NUM_LISTS];

    twpm_result_t pending_records[$];
    plan_row_t    plan[$];

    int errors          = 0;
    int cycles          = 0;
    int records_checked = 0;
    int empty_records   = 0;
    int split_records   = 0;
    int loads_taken     = 0;

    always #2 clk = ~clk;

    three_way_position_merge DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 30)
            $display("ERROR at cycle %0d: %s", cycles, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("record %0d %s: got %0h, expected %0h",
                                 records_checked, name, got, want));
    endtask

    // one beat through the shadow state; a next beat yields one record
    task automatic merge_step(input twpm_item_t it, output bit makes_record,
                              output twpm_result_t rec, output bit was_split);
        bit       found;
        bit       split;
        bit       have_min;
        pos_t     lowest;
        pos_t     min_st;
        bit       give [NUM_LISTS];
        out_idx_t gidx [NUM_LISTS];

        rec          = '0;
        makes_record = 1'b0;
        was_split    = 1'b0;
        if (it.opcode == OP_LOAD)
        begin
            if (it.sample <= LIST_LAST && list_len[it.sample] < LIST_DEPTH)
            begin
                list_orig[it.sample][list_len[it.sample]]  = it.original_position;
                list_start[it.sample][list_len[it.sample]] = it.start_position;
                list_len[it.sample]++;
            end
            return;
        end

        makes_record = 1'b1;
        rec.success  = 1'b1;
        if (emit_ptr[0] == gather_ptr[0] && emit_ptr[1] == gather_ptr[1] &&
            emit_ptr[2] == gather_ptr[2])
        begin
            found  = 1'b0;
            lowest = '0;
            for (int s = 0; s < NUM_LISTS; s++)
            begin
                if (gather_ptr[s] < list_len[s] &&
                    (!found || list_orig[s][gather_ptr[s]] < lowest))
                begin
                    lowest = list_orig[s][gather_ptr[s]];
                    found  = 1'b1;
                end
            end
            if (!found)
                rec.success = 1'b0;
            else
                for (int s = 0; s < NUM_LISTS; s++)
                    while (gather_ptr[s] < list_len[s] &&
                           list_orig[s][gather_ptr[s]] == lowest)
                        gather_ptr[s]++;
        end

        split = 1'b0;
        for (int s = 0; s < NUM_LISTS; s++)
            if (gather_ptr[s] - emit_ptr[s] > 1)
                split = 1'b1;

        // only non-empty windows compete for the smallest start
        have_min = 1'b0;
        min_st   = '0;
        if (split)
            for (int s = 0; s < NUM_LISTS; s++)
                if (emit_ptr[s] < gather_ptr[s] &&
                    (!have_min || list_start[s][emit_ptr[s]] < min_st))
                begin
                    min_st   = list_start[s][emit_ptr[s]];
                    have_min = 1'b1;
                end

        for (int s = 0; s < NUM_LISTS; s++)
        begin
            give[s] = emit_ptr[s] < gather_ptr[s] &&
                      (!split || list_start[s][emit_ptr[s]] == min_st);
            gidx[s] = give[s] ? out_idx_t'(emit_ptr[s]) : '0;
            if (!split)
                emit_ptr[s] = gather_ptr[s];
            else if (give[s])
                emit_ptr[s]++;
        end

        rec.mother_valid = give[MOTHER];
        rec.mother_index = gidx[MOTHER];
        rec.father_valid = give[FATHER];
        rec.father_index = gidx[FATHER];
        rec.child_valid  = give[CHILD];
        rec.child_index  = gidx[CHILD];
        was_split        = split;
    endtask

    function automatic twpm_item_t load_beat(input sel_t s, input pos_t o, input pos_t st);
        twpm_item_t b;
        b.opcode            = OP_LOAD;
        b.sample            = s;
        b.original_position = o;
        b.start_position    = st;
        return b;
    endfunction

    // unused fields of a next beat carry noise
    function automatic twpm_item_t next_beat();
        twpm_item_t b;
        b.opcode            = OP_NEXT;
        b.sample            = sel_t'($urandom_range(0, 3));
        b.original_position = pos_t'($urandom_range(0, POS_HIGH));
        b.start_position    = pos_t'($urandom_range(0, POS_HIGH));
        return b;
    endfunction

    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 15);
        return $urandom_range(16, 60);
    endfunction

    task automatic add_row(input twpm_item_t it, input bit has_exp, input twpm_result_t ex);
        plan_row_t row;
        row.it      = it;
        row.has_exp = has_exp;
        row.ex      = ex;
        plan.insert(plan.size(), row);
    endtask

    task automatic send_item(input twpm_item_t it, input bit has_exp, input twpm_result_t ex);
        int n;
        n = gap_cycles();
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        item         <= it;
        start        <= 1'b1;
        beat_has_exp <= has_exp;
        beat_exp     <= ex;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic lower_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_monitor
        twpm_result_t want;
        twpm_result_t pred;
        bit           makes;
        bit           split;

        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (pending_records.size() == 0)
                    flag_error("record arrived with none pending");
                else
                begin
                    want = pending_records.pop_front();
                    check_field("success",      32'(result.success),      32'(want.success));
                    check_field("mother_valid", 32'(result.mother_valid),
                                32'(want.mother_valid));
                    check_field("mother_index", 32'(result.mother_index),
                                32'(want.mother_index));
                    check_field("father_valid", 32'(result.father_valid),
                                32'(want.father_valid));
                    check_field("father_index", 32'(result.father_index),
                                32'(want.father_index));
                    check_field("child_valid",  32'(result.child_valid),
                                32'(want.child_valid));
                    check_field("child_index",  32'(result.child_index),
                                32'(want.child_index));
                    records_checked++;
                end
            end
            if (start === 1'b1 && busy === 1'b0)
            begin
                merge_step(item, makes, pred, split);
                if (makes)
                begin
                    pending_records.insert(pending_records.size(),
                                           beat_has_exp ? beat_exp : pred);
                    if (!pred.success)
                        empty_records++;
                    if (split)
                        split_records++;
                end
                else if (item.sample <= LIST_LAST)
                    loads_taken++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
            $display("** three_way_position_merge: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        twpm_item_t   batch[$];
        twpm_item_t   b;
        twpm_result_t first_of_all;
        longint       base;
        int           inc;
        int           nload;
        int           nnext;
        int           sent;
        int           waited;
        bit           mixed;
        pos_t         st;

        first_of_all              = '0;
        first_of_all.success      = 1'b1;
        first_of_all.mother_valid = 1'b1;
        first_of_all.father_valid = 1'b1;
        first_of_all.child_valid  = 1'b1;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty lists, ignored sample, singles, a split group,
        // exhaustion twice, loads after merging and an unsorted list
        add_row(next_beat(), 1'b1, '0);
        add_row(load_beat(NO_LIST, POS_HIGH, POS_HIGH), 1'b0, '0);
        add_row(next_beat(), 1'b1, '0);
        add_row(load_beat(MOTHER, 31'd0, 31'd5), 1'b0, '0);
        add_row(load_beat(FATHER, 31'd0, 31'd5), 1'b0, '0);
        add_row(load_beat(CHILD, 31'd0, 31'd5), 1'b0, '0);
        add_row(next_beat(), 1'b1, first_of_all);
        add_row(load_beat(MOTHER, 31'd10, 31'd3), 1'b0, '0);
        add_row(load_beat(MOTHER, 31'd10, 31'd7), 1'b0, '0);
        add_row(load_beat(FATHER, 31'd10, 31'd3), 1'b0, '0);
        add_row(load_beat(CHILD, POS_HIGH, POS_HIGH), 1'b0, '0);
        add_row(next_beat(), 1'b0, '0);
        add_row(next_beat(), 1'b0, '0);
        add_row(next_beat(), 1'b0, '0);
        add_row(next_beat(), 1'b1, '0);
        add_row(next_beat(), 1'b1, '0);
        add_row(load_beat(FATHER, 31'd20, 31'd0), 1'b0, '0);
        add_row(load_beat(FATHER, 31'd15, 31'd9), 1'b0, '0);
        add_row(load_beat(CHILD, 31'd20, 31'd0), 1'b0, '0);
        add_row(next_beat(), 1'b0, '0);
        add_row(next_beat(), 1'b0, '0);
        add_row(next_beat(), 1'b1, '0);
        foreach (plan[i])
            send_item(plan[i].it, plan[i].has_exp, plan[i].ex);

        // random: sorted position groups across the lists, then next beats,
        // with some short-changed or interleaved episodes and stray loads
        base = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            mixed   = ($urandom_range(0, 3) == 0);
            batch.delete();
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 9) < 8)
                    inc = $urandom_range(0, 3);
                else
                    inc = $urandom_range(0, 1 << 27);
                base = base + inc;
                if (base > POS_HIGH)
                    base = POS_HIGH;
                for (int s = 0; s < NUM_LISTS; s++)
                    repeat ($urandom_range(0, 2))
                    begin
                        if ($urandom_range(0, 3) != 0)
                            st = pos_t'($urandom_range(0, 4));
                        else
                            st = pos_t'($urandom_range(0, POS_HIGH));
                        batch.insert(batch.size(), load_beat(sel_t'(s), pos_t'(base), st));
                    end
            end
            if ($urandom_range(0, 5) == 0)
                batch.insert(batch.size(),
                             load_beat(NO_LIST, pos_t'($urandom_range(0, POS_HIGH)),
                                       pos_t'($urandom_range(0, POS_HIGH))));
            if ($urandom_range(0, 5) == 0)
                batch.insert(batch.size(),
                             load_beat(sel_t'($urandom_range(0, 2)),
                                       pos_t'($urandom_range(0, POS_HIGH)),
                                       pos_t'($urandom_range(0, POS_HIGH))));
            nload = batch.size();
            if ($urandom_range(0, 3) == 0)
                nnext = $urandom_range(0, nload);
            else
                nnext = nload + $urandom_range(0, 2);
            repeat (nnext)
            begin
                if (mixed)
                    batch.insert($urandom_range(0, batch.size()), next_beat());
                else
                    batch.insert(batch.size(), next_beat());
            end
            foreach (batch[i])
            begin
                b = batch[i];
                send_item(b, 1'b0, '0);
                if (!(b.opcode == OP_LOAD && b.sample == NO_LIST))
                    sent++;
            end
        end

        // merge everything out, then one more next beat on exhausted lists
        no_gaps = 1'b0;
        lower_start();
        do
        begin
            send_item(next_beat(), 1'b0, '0);
            lower_start();
        end
        while (!(emit_ptr[0] == list_len[0] && gather_ptr[0] == list_len[0] &&
                 emit_ptr[1] == list_len[1] && gather_ptr[1] == list_len[1] &&
                 emit_ptr[2] == list_len[2] && gather_ptr[2] == list_len[2]));
        send_item(next_beat(), 1'b0, '0);
        lower_start();

        waited = 0;
        while (pending_records.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_records.size() != 0)
            flag_error($sformatf("%0d records never arrived", pending_records.size()));

        $display("checked %0d records (%0d exhausted, %0d split by start) after %0d loads",
                 records_checked, empty_records, split_records, loads_taken);
        $display("random part sent %0d beats, then every list was merged out to the end",
                 sent);
        if (errors == 0)
            $display("** three_way_position_merge: PASSED **");
        else
            $display("** three_way_position_merge: FAILED **");
        $finish;
    end

endmodule
